// File: rtl/sbc_pkg.sv
// Shared types and constants of the sprite blitter with clipping and color key.
package sbc_pkg;

  localparam int TILE_SIDE = 35;
  localparam int COUNT_W   = 6;
  localparam logic [COUNT_W-1:0] TILE_LAST = COUNT_W'(TILE_SIDE - 1);

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_SCREEN_HEIGHT = 3'd1,
    REG_DEST_X        = 3'd2,
    REG_DEST_Y        = 3'd3,
    REG_SHEET_WIDTH   = 3'd4,
    REG_SHEET_HEIGHT  = 3'd5,
    REG_SRC_X         = 3'd6,
    REG_SRC_Y         = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic        [12:0] screen_width;
    logic        [12:0] screen_height;
    logic signed [12:0] dest_x;
    logic signed [12:0] dest_y;
    logic        [15:0] sheet_width;
    logic        [15:0] sheet_height;
    logic signed [15:0] src_x;
    logic signed [15:0] src_y;
  } cfg_t;

  // One classified pixel on its way from the front part to the back part.
  typedef struct packed {
    logic        write_enable;
    logic        last_of_tile;
    logic [12:0] dx;
    logic [12:0] dy;
    logic [23:0] color;
  } q_entry_t;

endpackage

// File: rtl/sbc_regs.sv
// Configuration register file of the sprite blitter.
module sbc_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sbc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sbc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output sbc_pkg::cfg_t                  cfg
);
  import sbc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width  <= 13'd800;
      cfg.screen_height <= 13'd600;
      cfg.dest_x        <= '0;
      cfg.dest_y        <= '0;
      cfg.sheet_width   <= 16'd256;
      cfg.sheet_height  <= 16'd256;
      cfg.src_x         <= '0;
      cfg.src_y         <= '0;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_SCREEN_WIDTH:  cfg.screen_width  <= cfg_data[12:0];
        REG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data[12:0];
        REG_DEST_X:        cfg.dest_x        <= cfg_data[12:0];
        REG_DEST_Y:        cfg.dest_y        <= cfg_data[12:0];
        REG_SHEET_WIDTH:   cfg.sheet_width   <= cfg_data;
        REG_SHEET_HEIGHT:  cfg.sheet_height  <= cfg_data;
        REG_SRC_X:         cfg.src_x         <= cfg_data;
        REG_SRC_Y:         cfg.src_y         <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/sbc_front.sv
// Front part: tile counters, bounds checks and color key classification.
module sbc_front (
  input  logic              clk,
  input  logic              rst,
  input  sbc_pkg::cfg_t     cfg,
  input  logic              in_valid,
  input  logic [31:0]       in_data,
  input  logic              in_has_alpha,
  input  logic              q_ready,
  output logic              push,
  output sbc_pkg::q_entry_t entry
);
  import sbc_pkg::*;

  logic [COUNT_W-1:0] tile_column;
  logic [COUNT_W-1:0] tile_row;
  logic [7:0]         blue, green, red, alpha;
  logic signed [13:0] dx, dy;
  logic signed [16:0] fx, fy;
  logic               in_bounds, visible;

  assign blue  = in_data[7:0];
  assign green = in_data[15:8];
  assign red   = in_data[23:16];
  assign alpha = in_data[31:24];

  assign push = in_valid && q_ready;

  always_comb begin
    dx = 14'({cfg.dest_x[12], cfg.dest_x}) + 14'({8'd0, tile_column});
    dy = 14'({cfg.dest_y[12], cfg.dest_y}) + 14'({8'd0, tile_row});
    fx = 17'({cfg.src_x[15], cfg.src_x}) + 17'({11'd0, tile_column});
    fy = 17'({cfg.src_y[15], cfg.src_y}) + 17'({11'd0, tile_row});
    // A nonnegative sum is below 2^13 (or 2^16), so the low bits compare directly.
    in_bounds = !dx[13] && (dx[12:0] < cfg.screen_width)
             && !dy[13] && (dy[12:0] < cfg.screen_height)
             && !fx[16] && (fx[15:0] < cfg.sheet_width)
             && !fy[16] && (fy[15:0] < cfg.sheet_height);
    visible = in_has_alpha ? (alpha != 8'd0) : ({red, green, blue} != 24'd0);
    entry.write_enable = in_bounds && visible;
    entry.last_of_tile = (tile_column == TILE_LAST) && (tile_row == TILE_LAST);
    entry.dx           = dx[12:0];
    entry.dy           = dy[12:0];
    entry.color        = {red, green, blue};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_column <= '0;
      tile_row    <= '0;
    end else if (push) begin
      if (tile_column == TILE_LAST) begin
        tile_column <= '0;
        tile_row    <= (tile_row == TILE_LAST) ? '0 : tile_row + 1'b1;
      end else begin
        tile_column <= tile_column + 1'b1;
      end
    end
  end

endmodule

// File: rtl/sbc_queue.sv
// Two-entry queue between the front and back parts.
module sbc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sbc_pkg::q_entry_t push_entry,
  output logic              ready,
  input  logic              pop,
  output logic              valid,
  output sbc_pkg::q_entry_t head
);
  import sbc_pkg::*;

  q_entry_t   slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign ready = (count != 2'd2);
  assign valid = (count != 2'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/sbc_back.sv
// Back part: address multiply, address add and the output register.
module sbc_back (
  input  logic              clk,
  input  logic              rst,
  input  logic [12:0]       screen_width,
  input  logic              q_valid,
  input  sbc_pkg::q_entry_t q_head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [47:0]       out_data,
  output logic              out_we,
  output logic              out_last
);
  import sbc_pkg::*;

  logic        mul_valid;
  logic [25:0] mul_product;
  logic [12:0] mul_dx;
  logic [23:0] mul_color;
  logic        mul_we;
  logic        mul_last;
  logic        out_advance, mul_advance;
  logic [23:0] addr_next;

  assign out_advance = !out_valid || out_ready;
  assign mul_advance = !mul_valid || out_advance;
  assign pop         = q_valid && mul_advance;
  assign addr_next   = mul_product[23:0] + {11'd0, mul_dx};

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (mul_advance) mul_valid <= q_valid;
      if (out_advance) out_valid <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      mul_product <= q_head.dy * screen_width;
      mul_dx      <= q_head.dx;
      mul_color   <= q_head.color;
      mul_we      <= q_head.write_enable;
      mul_last    <= q_head.last_of_tile;
    end
    if (out_advance && mul_valid) begin
      // A pixel that is not written shows zero address and color.
      out_data <= mul_we ? {mul_color, addr_next} : 48'd0;
      out_we   <= mul_we;
      out_last <= mul_last;
    end
  end

endmodule

// File: rtl/sprite_blit_clip_colorkey.sv
// Sprite tile blitter with screen and sheet clipping and a color key.
// Takes one source pixel per clock in raster order of a 35 by 35 tile and gives one word
// per pixel: write enable, linear screen address (row times screen width plus column),
// packed RGB color and a tile-end mark. Sustained rate is one pixel per clock while the output
// is ready; a pixel passes through a queue slot, the multiplier stage and the output register.
// The front takes pixels while the two-entry queue has room, so a stalled output holds off the
// input only once the queue is full. The user must write configuration only while no pixel is
// in flight; the block does not enforce it. The tile counters restart after the last pixel.
module sprite_blit_clip_colorkey (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [31:0]                     s_axis_tdata,  // blue, green, red, alpha
  input  logic                            s_axis_tuser,  // has_alpha
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [47:0]                     m_axis_tdata,  // dest_address, color
  output logic                            m_axis_tuser,  // write_enable
  output logic                            m_axis_tlast,  // last_of_tile
  input  logic                            cfg_we,
  input  logic [sbc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sbc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sbc_pkg::*;

  cfg_t     cfg;
  q_entry_t push_entry, q_head;
  logic     push, pop, q_ready, q_valid;

  assign s_axis_tready = q_ready;

  sbc_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sbc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (s_axis_tvalid),
    .in_data      (s_axis_tdata),
    .in_has_alpha (s_axis_tuser),
    .q_ready      (q_ready),
    .push         (push),
    .entry        (push_entry)
  );

  sbc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .ready      (q_ready),
    .pop        (pop),
    .valid      (q_valid),
    .head       (q_head)
  );

  sbc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .screen_width (cfg.screen_width),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .pop          (pop),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_data     (m_axis_tdata),
    .out_we       (m_axis_tuser),
    .out_last     (m_axis_tlast)
  );

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the sprite blitter: random tiles, clipping windows and color keys.
`timescale 1ns / 1ps

module testbench;
  import sbc_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_PHASES = 12;
  localparam int PIXELS_PER_PHASE = 140;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] alpha;
    logic       has_alpha;
  } src_pixel_t;

  typedef struct packed {
    logic        write_enable;
    logic [23:0] dest_address;
    logic [23:0] color;
    logic        last_of_tile;
  } blit_word_t;

  // Predicts the screen write of each pixel and keeps the writes still owed by the block.
  class pixel_write_scoreboard;
    cfg_t regs;
    logic [COUNT_W-1:0] tile_column;
    logic [COUNT_W-1:0] tile_row;
    blit_word_t pending_writes[$];
    int errors;

    function new();
      regs.screen_width  = 13'd800;
      regs.screen_height = 13'd600;
      regs.dest_x        = '0;
      regs.dest_y        = '0;
      regs.sheet_width   = 16'd256;
      regs.sheet_height  = 16'd256;
      regs.src_x         = '0;
      regs.src_y         = '0;
      tile_column = '0;
      tile_row    = '0;
      errors      = 0;
    endfunction

    function void set_reg(reg_index_t idx, logic [15:0] value);
      case (idx)
        REG_SCREEN_WIDTH:  regs.screen_width  = value[12:0];
        REG_SCREEN_HEIGHT: regs.screen_height = value[12:0];
        REG_DEST_X:        regs.dest_x        = value[12:0];
        REG_DEST_Y:        regs.dest_y        = value[12:0];
        REG_SHEET_WIDTH:   regs.sheet_width   = value;
        REG_SHEET_HEIGHT:  regs.sheet_height  = value;
        REG_SRC_X:         regs.src_x         = value;
        REG_SRC_Y:         regs.src_y         = value;
        default: ;
      endcase
    endfunction

    function void note_pixel(src_pixel_t p);
      int col, row, dx, dy, fx, fy;
      bit in_bounds, visible;
      blit_word_t w;
      col = int'(tile_column);
      row = int'(tile_row);
      dx = int'($signed(regs.dest_x)) + col;
      dy = int'($signed(regs.dest_y)) + row;
      fx = int'($signed(regs.src_x)) + col;
      fy = int'($signed(regs.src_y)) + row;
      in_bounds = dx >= 0 && dx < int'(regs.screen_width) &&
                  dy >= 0 && dy < int'(regs.screen_height) &&
                  fx >= 0 && fx < int'(regs.sheet_width) &&
                  fy >= 0 && fy < int'(regs.sheet_height);
      visible = p.has_alpha ? (p.alpha != 8'd0) : ({p.red, p.green, p.blue} != 24'd0);
      w.write_enable = in_bounds && visible;
      w.last_of_tile = (tile_column == TILE_LAST) && (tile_row == TILE_LAST);
      w.dest_address = '0;
      w.color        = '0;
      if (w.write_enable) begin
        // The product fits an int here: dy stays below 8191 once it passed the bounds check.
        w.dest_address = 24'(dy * int'(regs.screen_width) + dx);
        w.color        = {p.red, p.green, p.blue};
      end
      pending_writes.push_back(w);
      if (tile_column == TILE_LAST) begin
        tile_column = '0;
        tile_row = (tile_row == TILE_LAST) ? '0 : tile_row + 1'b1;
      end else begin
        tile_column = tile_column + 1'b1;
      end
    endfunction

    function void compare_field(string field, logic [23:0] want, logic [23:0] got);
      if (got !== want) begin
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_write(blit_word_t got);
      blit_word_t want;
      if (pending_writes.size() == 0) begin
        $display("%0t ns: output word with nothing expected, expected none, actual %0h",
                 $time, got);
        errors++;
        return;
      end
      want = pending_writes.pop_front();
      compare_field("write_enable", 24'(want.write_enable), 24'(got.write_enable));
      compare_field("dest_address", want.dest_address, got.dest_address);
      compare_field("color", want.color, got.color);
      compare_field("last_of_tile", 24'(want.last_of_tile), 24'(got.last_of_tile));
    endfunction

    function int pending();
      return pending_writes.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // blue, green, red, alpha
  logic        s_axis_tuser;   // has_alpha
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // dest_address, color
  logic        m_axis_tuser;   // write_enable
  logic        m_axis_tlast;   // last_of_tile
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  pixel_write_scoreboard sb;
  int sender_idle_pct;
  int recv_idle_pct;
  int hold_left;
  int quiet_cycles;

  sprite_blit_clip_colorkey dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Output side: random back-pressure, plus a long hold-off when one is requested.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_write('{write_enable: m_axis_tuser, dest_address: m_axis_tdata[23:0],
                       color: m_axis_tdata[47:24], last_of_tile: m_axis_tlast});
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic src_pixel_t make_pixel(logic has_alpha, logic [7:0] alpha,
                                            logic [23:0] rgb);
    src_pixel_t p;
    p.has_alpha = has_alpha;
    p.alpha = alpha;
    {p.red, p.green, p.blue} = rgb;
    return p;
  endfunction

  function automatic src_pixel_t random_pixel();
    src_pixel_t p;
    p.has_alpha = 1'($urandom_range(1));
    p.alpha = 8'($urandom_range(255));
    p.red   = 8'($urandom_range(255));
    p.green = 8'($urandom_range(255));
    p.blue  = 8'($urandom_range(255));
    // Keyed pixels must be common for both sheet formats.
    case ($urandom_range(4))
      0: p.alpha = 8'd0;
      1: {p.red, p.green, p.blue} = 24'd0;
      default: ;
    endcase
    return p;
  endfunction

  function automatic logic [15:0] pick_size(int top);
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'(top);
      3, 4: return 16'($urandom_range(1, 4096));
      default: return 16'($urandom_range(1, 48));
    endcase
  endfunction

  // Mostly places the tile so that it straddles an edge of the window.
  function automatic logic [15:0] pick_origin(logic [15:0] size);
    case ($urandom_range(5))
      0: return 16'($urandom_range(65535));
      1: return 16'(int'(size) - $urandom_range(1, 34));
      2: return 16'(-$urandom_range(1, 34));
      default: return 16'($urandom_range(40) - 20);
    endcase
  endfunction

  task automatic write_reg(reg_index_t idx, logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    sb.set_reg(idx, value);
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_config();
    logic [15:0] sw, sh, shw, shh;
    sw  = pick_size(8191);
    sh  = pick_size(8191);
    shw = pick_size(65535);
    shh = pick_size(65535);
    write_reg(REG_SCREEN_WIDTH, sw);
    write_reg(REG_SCREEN_HEIGHT, sh);
    write_reg(REG_DEST_X, pick_origin(sw));
    write_reg(REG_DEST_Y, pick_origin(sh));
    write_reg(REG_SHEET_WIDTH, shw);
    write_reg(REG_SHEET_HEIGHT, shh);
    write_reg(REG_SRC_X, pick_origin(shw));
    write_reg(REG_SRC_Y, pick_origin(shh));
    end_writes();
  endtask

  task automatic push_pixel(src_pixel_t p);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < sender_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {p.alpha, p.red, p.green, p.blue};
    s_axis_tuser  <= p.has_alpha;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_pixel(p);
  endtask

  // Lets the pipeline empty before the registers change.
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = REG_SCREEN_WIDTH;
    cfg_data      = '0;
    quiet_cycles  = 0;
    hold_left     = 0;
    sender_idle_pct = 15;
    recv_idle_pct   = 80;
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Color key cases under the reset window.
    push_pixel(make_pixel(1'b0, 8'h00, 24'h000000));
    push_pixel(make_pixel(1'b0, 8'h00, 24'h000001));
    push_pixel(make_pixel(1'b0, 8'h00, 24'h008000));
    push_pixel(make_pixel(1'b0, 8'hFF, 24'hFF0000));
    push_pixel(make_pixel(1'b0, 8'h00, 24'hFFFFFF));
    push_pixel(make_pixel(1'b1, 8'h00, 24'hFFFFFF));
    push_pixel(make_pixel(1'b1, 8'hFF, 24'h000000));
    push_pixel(make_pixel(1'b1, 8'h01, 24'h123456));
    push_pixel(make_pixel(1'b1, 8'h80, 24'hFFFFFF));
    push_pixel(make_pixel(1'b0, 8'h55, 24'hAA55AA));
    settle();

    // A zero screen width clips everything.
    write_reg(REG_SCREEN_WIDTH, 16'd0);
    end_writes();
    repeat (3) push_pixel(make_pixel(1'b1, 8'hFF, 24'hFFFFFF));
    settle();

    // A zero sheet height clips everything too.
    write_reg(REG_SCREEN_WIDTH, 16'd800);
    write_reg(REG_SHEET_HEIGHT, 16'd0);
    end_writes();
    repeat (3) push_pixel(make_pixel(1'b0, 8'h00, 24'hFFFFFF));
    settle();

    // Largest screen, tile at the largest positive destination origin: the address wraps at 24 bits.
    // The upper data bits of the 13-bit registers must be dropped.
    write_reg(REG_SCREEN_WIDTH, 16'hFFFF);
    write_reg(REG_SCREEN_HEIGHT, 16'hFFFF);
    write_reg(REG_DEST_X, 16'h0FFF);
    write_reg(REG_DEST_Y, 16'h0FFF);
    write_reg(REG_SHEET_WIDTH, 16'hFFFF);
    write_reg(REG_SHEET_HEIGHT, 16'hFFFF);
    write_reg(REG_SRC_X, 16'h0000);
    write_reg(REG_SRC_Y, 16'h0000);
    end_writes();
    push_pixel(make_pixel(1'b1, 8'hFF, 24'hFFFFFF));
    push_pixel(make_pixel(1'b0, 8'h00, 24'h00FF00));
    push_pixel(make_pixel(1'b1, 8'h7F, 24'h0000FF));
    push_pixel(make_pixel(1'b0, 8'hFF, 24'h800000));
    settle();

    // Most negative X origins, destination Y at zero and the largest positive source Y.
    write_reg(REG_DEST_X, 16'h1000);
    write_reg(REG_DEST_Y, 16'h0000);
    write_reg(REG_SRC_X, 16'h8000);
    write_reg(REG_SRC_Y, 16'h7FFF);
    end_writes();
    repeat (3) push_pixel(make_pixel(1'b1, 8'hFF, 24'hFFFFFF));
    settle();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == RANDOM_PHASES / 3) begin
        sender_idle_pct = 80;
        recv_idle_pct   = 15;
      end else if (phase == 2 * RANDOM_PHASES / 3) begin
        sender_idle_pct = 0;
        recv_idle_pct   = 0;
        // The sender keeps offering while the output is held; the input must stall.
        hold_left = 300;
      end
      random_config();
      repeat (PIXELS_PER_PHASE) push_pixel(random_pixel());
      settle();
    end

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
